@@ rtl/vbf_pkg.sv @@
// Shared constants, codes and types of the voxel box fill counter.
`timescale 1ns / 1ps

package vbf_pkg;

  // Field widths.
  localparam int COORD_W = 18;
  localparam int WIN_W   = 7;
  localparam int COUNT_W = 22;

  // Default side of the cubic voxel map.
  localparam int GRID_SIDE_DEF = 128;

  // Window register reset values.
  localparam logic signed [WIN_W-1:0] WIN_LOW_RST  = -7'sd50;
  localparam logic signed [WIN_W-1:0] WIN_HIGH_RST = 7'sd50;

  // Configuration port geometry.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register index codes, taken from the word address bit.
  localparam logic REG_WINDOW_LOW  = 1'b0;
  localparam logic REG_WINDOW_HIGH = 1'b1;

  // One input request.
  typedef struct packed {
    logic                      action;
    logic signed [COORD_W-1:0] x_low;
    logic signed [COORD_W-1:0] x_high;
    logic signed [COORD_W-1:0] y_low;
    logic signed [COORD_W-1:0] y_high;
    logic signed [COORD_W-1:0] z_low;
    logic signed [COORD_W-1:0] z_high;
  } item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic load_row;
    logic mod_step;
    logic write_row;
    logic clear_step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_empty;
    logic last_z;
    logic last_row;
    logic clear_done;
  } status_t;

endpackage

@@ rtl/vbf_if.sv @@
// Valid/ready channel interfaces for box requests and count results.
`timescale 1ns / 1ps

interface vbf_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic signed [vbf_pkg::COORD_W-1:0] x_low;
  logic signed [vbf_pkg::COORD_W-1:0] x_high;
  logic signed [vbf_pkg::COORD_W-1:0] y_low;
  logic signed [vbf_pkg::COORD_W-1:0] y_high;
  logic signed [vbf_pkg::COORD_W-1:0] z_low;
  logic signed [vbf_pkg::COORD_W-1:0] z_high;

  modport source (output valid, action, x_low, x_high, y_low, y_high, z_low, z_high,
                  input ready);
  modport sink   (input valid, action, x_low, x_high, y_low, y_high, z_low, z_high,
                  output ready);
endinterface

interface vbf_out_if;
  logic                         valid;
  logic                         ready;
  logic [vbf_pkg::COUNT_W-1:0]  on_count;

  modport source (output valid, on_count, input ready);
  modport sink   (input valid, on_count, output ready);
endinterface

@@ rtl/vbf_cfg_regs.sv @@
// Window configuration registers behind an APB-style port.
`timescale 1ns / 1ps

module vbf_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vbf_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [vbf_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [vbf_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  output logic signed [vbf_pkg::WIN_W-1:0]    window_low,
  output logic signed [vbf_pkg::WIN_W-1:0]    window_high
);

  logic signed [vbf_pkg::WIN_W-1:0] window_low_r;
  logic signed [vbf_pkg::WIN_W-1:0] window_high_r;
  logic                             wr_en;
  logic [vbf_pkg::WIN_W-1:0]        rd_sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes in the access phase; the word address bit picks the register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_low_r  <= vbf_pkg::WIN_LOW_RST;
      window_high_r <= vbf_pkg::WIN_HIGH_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        vbf_pkg::REG_WINDOW_LOW:  window_low_r  <= pwdata[vbf_pkg::WIN_W-1:0];
        vbf_pkg::REG_WINDOW_HIGH: window_high_r <= pwdata[vbf_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data, zero extended to the bus width.
  always_comb begin
    unique case (paddr[2])
      vbf_pkg::REG_WINDOW_LOW:  rd_sel = window_low_r;
      vbf_pkg::REG_WINDOW_HIGH: rd_sel = window_high_r;
      default:                  rd_sel = '0;
    endcase
  end

  assign prdata      = {{(vbf_pkg::APB_DATA_W - vbf_pkg::WIN_W){1'b0}}, rd_sel};
  assign window_low  = window_low_r;
  assign window_high = window_high_r;

endmodule

@@ rtl/vbf_datapath.sv @@
// Box clipping, row memory, voxel update and running count.
`timescale 1ns / 1ps

module vbf_datapath #(
  parameter int GRID_SIDE = vbf_pkg::GRID_SIDE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vbf_pkg::item_t                    item,
  input  logic signed [vbf_pkg::WIN_W-1:0]  window_low,
  input  logic signed [vbf_pkg::WIN_W-1:0]  window_high,
  input  vbf_pkg::cmd_t                     cmd,
  output vbf_pkg::status_t                  status,
  output logic [vbf_pkg::COUNT_W-1:0]       on_count
);

  localparam int HALF  = GRID_SIDE / 2;
  localparam int CW    = $clog2(GRID_SIDE);
  localparam int ROWS  = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(ROWS);
  localparam int CRD_W = vbf_pkg::COORD_W;
  localparam int CNT_W = vbf_pkg::COUNT_W;

  localparam logic signed [CRD_W-1:0] MAP_LO = CRD_W'(-HALF);
  localparam logic signed [CRD_W-1:0] MAP_HI = CRD_W'(HALF - 1);
  localparam logic [AW-1:0]           CLR_LAST = AW'(ROWS - 1);

  // Bounds of the incoming box, one entry per axis.
  logic signed [CRD_W-1:0] b_lo [3];
  logic signed [CRD_W-1:0] b_hi [3];
  logic signed [CRD_W-1:0] c_lo [3];
  logic signed [CRD_W-1:0] c_hi [3];
  logic signed [CRD_W-1:0] w_lo;
  logic signed [CRD_W-1:0] w_hi;
  logic signed [CRD_W-1:0] sw_lo;
  logic signed [CRD_W-1:0] sw_hi;
  logic [CRD_W-1:0]        idx_lo [3];
  logic [CRD_W-1:0]        idx_hi [3];
  logic                    empty;

  // Loop state.
  logic [CW-1:0]  hi_x_r, lo_y_r, hi_y_r, lo_z_r, hi_z_r;
  logic [CW-1:0]  x_r, y_r, z_r;
  logic           on_r;
  logic [GRID_SIDE-1:0] row_r;
  logic [CNT_W-1:0]     total_r;
  logic [CNT_W-1:0]     on_count_r;
  logic [AW-1:0]        clr_addr_r;

  // Row memory: one word holds a full z line of voxels.
  logic [GRID_SIDE-1:0] row_mem [ROWS];
  logic [GRID_SIDE-1:0] mem_q_r;
  logic [AW-1:0]        row_addr;
  logic [AW-1:0]        wr_addr;
  logic [GRID_SIDE-1:0] wr_data;
  logic                 mem_we;
  logic                 cur_bit;

  assign b_lo[0] = item.x_low;
  assign b_hi[0] = item.x_high;
  assign b_lo[1] = item.y_low;
  assign b_hi[1] = item.y_high;
  assign b_lo[2] = item.z_low;
  assign b_hi[2] = item.z_high;

  // Window limited to the map's coordinate range.
  assign sw_lo = CRD_W'(window_low);
  assign sw_hi = CRD_W'(window_high);
  assign w_lo  = (sw_lo > MAP_LO) ? sw_lo : MAP_LO;
  assign w_hi  = (sw_hi < MAP_HI) ? sw_hi : MAP_HI;

  // Clip each axis to the window; an axis left with no span empties the box,
  // which also covers a box outside the window and an inverted window.
  always_comb begin
    empty = 1'b0;
    for (int a = 0; a < 3; a++) begin
      c_lo[a]   = (b_lo[a] > w_lo) ? b_lo[a] : w_lo;
      c_hi[a]   = (b_hi[a] < w_hi) ? b_hi[a] : w_hi;
      idx_lo[a] = c_lo[a] - MAP_LO;
      idx_hi[a] = c_hi[a] - MAP_LO;
      if (c_lo[a] > c_hi[a]) begin
        empty = 1'b1;
      end
    end
  end

  // Row address from the x and y counters.
  assign row_addr = AW'(x_r) * AW'(GRID_SIDE) + AW'(y_r);
  assign mem_we   = cmd.write_row || cmd.clear_step;
  assign wr_addr  = cmd.clear_step ? clr_addr_r : row_addr;
  assign wr_data  = cmd.clear_step ? '0 : row_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[wr_addr] <= wr_data;
    end
    mem_q_r <= row_mem[row_addr];
  end

  assign cur_bit = row_r[z_r];

  // Clearing sweep counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear_step && (clr_addr_r != CLR_LAST)) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // Running count of set voxels; moves only when a voxel changes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (cmd.mod_step) begin
      if (on_r && !cur_bit) begin
        total_r <= total_r + 1'b1;
      end else if (!on_r && cur_bit) begin
        total_r <= total_r - 1'b1;
      end
    end
  end

  // Box bounds, loop counters, row buffer and result register.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      on_r   <= item.action;
      hi_x_r <= idx_hi[0][CW-1:0];
      lo_y_r <= idx_lo[1][CW-1:0];
      hi_y_r <= idx_hi[1][CW-1:0];
      lo_z_r <= idx_lo[2][CW-1:0];
      hi_z_r <= idx_hi[2][CW-1:0];
      x_r    <= idx_lo[0][CW-1:0];
      y_r    <= idx_lo[1][CW-1:0];
    end
    if (cmd.load_row) begin
      row_r <= mem_q_r;
      z_r   <= lo_z_r;
    end
    if (cmd.mod_step) begin
      row_r[z_r] <= on_r;
      z_r        <= z_r + 1'b1;
    end
    if (cmd.write_row) begin
      if (y_r == hi_y_r) begin
        y_r <= lo_y_r;
        x_r <= x_r + 1'b1;
      end else begin
        y_r <= y_r + 1'b1;
      end
    end
    if (cmd.load_out) begin
      on_count_r <= total_r;
    end
  end

  assign status.item_empty = empty;
  assign status.last_z     = (z_r == hi_z_r);
  assign status.last_row   = (x_r == hi_x_r) && (y_r == hi_y_r);
  assign status.clear_done = (clr_addr_r == CLR_LAST);
  assign on_count          = on_count_r;

endmodule

@@ rtl/vbf_ctrl.sv @@
// Sequencer for the clearing sweep and the row by row box walk.
`timescale 1ns / 1ps

module vbf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  vbf_pkg::status_t status,
  output vbf_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW_RD,
    ST_ROW_LD,
    ST_ROW_MOD,
    ST_ROW_WR,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = status.item_empty ? ST_DONE : ST_ROW_RD;
        end
      end
      ST_ROW_RD: begin
        state_nxt = ST_ROW_LD;
      end
      ST_ROW_LD: begin
        cmd.load_row = 1'b1;
        state_nxt    = ST_ROW_MOD;
      end
      ST_ROW_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.last_z) begin
          state_nxt = ST_ROW_WR;
        end
      end
      ST_ROW_WR: begin
        cmd.write_row = 1'b1;
        state_nxt     = status.last_row ? ST_DONE : ST_ROW_RD;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/voxel_box_fill_count_unit.sv @@
// Top level of the voxel box fill counter.
`timescale 1ns / 1ps

// Fills or clears an inclusive box of voxels in a GRID_SIDE cubed bit map and
// reports the number of set voxels after each request. The map is held as one
// memory word per z line; the box is walked line by line, each line being read,
// updated one voxel per cycle and written back. After reset a clearing sweep
// writes every line of the memory once, during which no request is taken;
// window writes are accepted throughout. A finished count waits in an output
// register, so the next request can start while it is still pending.
module voxel_box_fill_count_unit #(
  parameter int GRID_SIDE = vbf_pkg::GRID_SIDE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  vbf_in_if.sink                         in_ch,
  vbf_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vbf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [vbf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [vbf_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  vbf_pkg::item_t                   item;
  vbf_pkg::cmd_t                    cmd;
  vbf_pkg::status_t                 status;
  logic signed [vbf_pkg::WIN_W-1:0] window_low;
  logic signed [vbf_pkg::WIN_W-1:0] window_high;

  // Gather the request payload.
  assign item.action = in_ch.action;
  assign item.x_low  = in_ch.x_low;
  assign item.x_high = in_ch.x_high;
  assign item.y_low  = in_ch.y_low;
  assign item.y_high = in_ch.y_high;
  assign item.z_low  = in_ch.z_low;
  assign item.z_high = in_ch.z_high;

  vbf_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .window_low  (window_low),
    .window_high (window_high)
  );

  vbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  vbf_datapath #(
    .GRID_SIDE (GRID_SIDE)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .item        (item),
    .window_low  (window_low),
    .window_high (window_high),
    .cmd         (cmd),
    .status      (status),
    .on_count    (out_ch.on_count)
  );

  // No request is taken while the memory is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_step |-> !in_ch.ready)
    else $error("request taken during clearing sweep");

  // An accepted request occupies the block for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("block ready directly after accepting a request");

  // A new count never overwrites one that has not been taken.
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_ch.valid || out_ch.ready))
    else $error("pending result overwritten");

  // The box walk and the clearing sweep never run together.
  a_walk_excludes_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mod_step || cmd.write_row || cmd.load_row) |-> !cmd.clear_step)
    else $error("box walk overlaps clearing sweep");

endmodule
